/* sv/binary_morphology_square_window_core_assert.svh */
// ----------------------------------------------------------------------------
// Binary morphology core - assertion macros
// Short forms for the concurrent checks used inside the core.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_SQUARE_WINDOW_CORE_ASSERT_SVH
`define BINARY_MORPHOLOGY_SQUARE_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, skipped while reset is held
`define BMSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, skipped while reset is held
`define BMSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* sv/bmsw_pkg.sv */
// ----------------------------------------------------------------------------
// Binary morphology package
// Sizes, codes and shared types of the square-window erode/dilate core.
// ----------------------------------------------------------------------------
package bmsw_pkg;

    localparam int MAX_MASK   = 15;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    // line store keeps the marks of the previous rows only
    localparam int LS_W  = MAX_MASK - 1;

    localparam int PIX_W  = 8;
    localparam int MASK_W = 4;
    localparam int DIM_W  = 11;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [PIX_W-1:0] FG_LEVEL = PIX_W'(255);
    localparam logic [PIX_W-1:0] BG_LEVEL = '0;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE,
        CFG_MASK_SIZE,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } t_result;

    typedef struct packed {
        logic all_set;
        logic any_set;
    } t_col_flags;

endpackage

/* sv/bmsw_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module bmsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bmsw_cell.sv */
// ----------------------------------------------------------------------------
// Window column cell
// Holds one column of foreground marks, hands it on to the next cell on each
// shift and reports whether its enabled rows are all set / any set.
// ----------------------------------------------------------------------------
module bmsw_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [bmsw_pkg::MAX_MASK-1:0] i_col,
    input  logic [bmsw_pkg::MAX_MASK-1:0] i_row_en,
    output logic [bmsw_pkg::MAX_MASK-1:0] o_col,
    output bmsw_pkg::t_col_flags          o_flags
);

    logic [bmsw_pkg::MAX_MASK-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col           = r_col;
    assign o_flags.all_set = &(r_col | ~i_row_en);
    assign o_flags.any_set = |(r_col & i_row_en);

endmodule

/* sv/bmsw_outq.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small register FIFO between the window logic and the result channel.
// ----------------------------------------------------------------------------
module bmsw_outq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bmsw_pkg::t_result            i_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output bmsw_pkg::t_result            o_data,
    output logic [bmsw_pkg::OUTQ_CW-1:0] o_count
);

    bmsw_pkg::t_result            r_mem [bmsw_pkg::OUTQ_DEPTH];
    logic [bmsw_pkg::OUTQ_AW-1:0] r_wr_ptr;
    logic [bmsw_pkg::OUTQ_AW-1:0] r_rd_ptr;
    logic [bmsw_pkg::OUTQ_CW-1:0] r_count;
    logic                         w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == bmsw_pkg::OUTQ_AW'(bmsw_pkg::OUTQ_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == bmsw_pkg::OUTQ_AW'(bmsw_pkg::OUTQ_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* sv/binary_morphology_square_window_core.sv */
// ----------------------------------------------------------------------------
// Binary morphology core, square window
// Streams a padded 8-bit frame, keeps per-column mark history in a line store
// and a sliding row of column cells, and gives erode/dilate results.
//
//   channel   direction  handshake          payload
//   pixel     in         i_valid/o_stall    i_pixel
//   result    out        o_valid/i_stall    o_result_value, o_out_col,
//                                           o_out_row, o_frame_done
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One pixel per cycle while o_stall is low; a result passes the line store read at
// its pixel beat, the cell shift and the window reduce before it enters the queue.
// Reset is synchronous; the line store needs no clearing pass.
// o_stall rises once 4 beats are in flight or queued, so a stalled result
// channel backs up into the pixel channel after 4 beats that carry results.
// ----------------------------------------------------------------------------
`include "binary_morphology_square_window_core_assert.svh"

module binary_morphology_square_window_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bmsw_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bmsw_pkg::PIX_W-1:0]   o_result_value,
    output logic [bmsw_pkg::POS_W-1:0]   o_out_col,
    output logic [bmsw_pkg::POS_W-1:0]   o_out_row,
    output logic                         o_frame_done,
    input  logic                         i_cfg_we,
    input  logic [bmsw_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bmsw_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int MM    = bmsw_pkg::MAX_MASK;
    localparam int CW    = bmsw_pkg::COL_W;
    localparam int RW    = bmsw_pkg::ROW_W;
    localparam int INF_W = bmsw_pkg::OUTQ_CW + 1;

    // configuration
    logic                        r_mode;
    logic [bmsw_pkg::MASK_W-1:0] r_mask;
    logic [bmsw_pkg::DIM_W-1:0]  r_fw;
    logic [bmsw_pkg::DIM_W-1:0]  r_fh;

    logic [bmsw_pkg::MASK_W-1:0] w_m;
    logic [bmsw_pkg::MASK_W-1:0] w_half;
    logic [bmsw_pkg::DIM_W-1:0]  w_w;
    logic [bmsw_pkg::DIM_W-1:0]  w_h;
    logic [MM-1:0]               w_row_en;

    // position of the next pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // stage 0
    logic                       w_acc;
    logic                       w_mark;
    logic [bmsw_pkg::DIM_W:0]   w_c1;
    logic [bmsw_pkg::DIM_W:0]   w_r1;
    logic                       w_last_col;
    logic                       w_last_row;
    logic                       w_has_res;
    logic [bmsw_pkg::DIM_W:0]   w_pos_c;
    logic [bmsw_pkg::DIM_W:0]   w_pos_r;
    logic                       w_hit;

    // stage 1
    logic                       r_s1_v;
    logic                       r_s1_mark;
    logic [CW-1:0]              r_s1_addr;
    logic                       r_s1_hit;
    logic [bmsw_pkg::LS_W-1:0]  r_s1_byp;
    logic                       r_s1_res;
    logic [bmsw_pkg::POS_W-1:0] r_s1_pc;
    logic [bmsw_pkg::POS_W-1:0] r_s1_pr;
    logic                       r_s1_done;
    logic [bmsw_pkg::LS_W-1:0]  w_ls_rd;
    logic [bmsw_pkg::LS_W-1:0]  w_prev;
    logic [bmsw_pkg::LS_W-1:0]  w_ls_wr;
    logic [MM-1:0]              w_new_col;

    // stage 2
    logic                       r_s2_v;
    logic                       r_s2_res;
    logic [bmsw_pkg::POS_W-1:0] r_s2_pc;
    logic [bmsw_pkg::POS_W-1:0] r_s2_pr;
    logic                       r_s2_done;

    logic [MM-1:0]              w_chain [MM+1];
    bmsw_pkg::t_col_flags       w_flags [MM];
    logic [MM-1:0]              w_all_v;
    logic [MM-1:0]              w_any_v;
    logic                       w_win_all;
    logic                       w_win_any;

    logic                       w_push;
    bmsw_pkg::t_result          w_res;
    bmsw_pkg::t_result          w_q_data;
    logic [bmsw_pkg::OUTQ_CW-1:0] w_q_count;
    logic [INF_W-1:0]           w_inflight;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bmsw_pkg::MODE_ERODE;
            r_mask <= bmsw_pkg::MASK_W'(3);
            r_fw   <= bmsw_pkg::DIM_W'(bmsw_pkg::MAX_WIDTH);
            r_fh   <= bmsw_pkg::DIM_W'(bmsw_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (bmsw_pkg::t_cfg_idx'(i_cfg_idx))
                bmsw_pkg::CFG_MODE:         r_mode <= i_cfg_data[0];
                bmsw_pkg::CFG_MASK_SIZE:    r_mask <= i_cfg_data[bmsw_pkg::MASK_W-1:0];
                bmsw_pkg::CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data[bmsw_pkg::DIM_W-1:0];
                bmsw_pkg::CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data[bmsw_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_mask == '0) begin
            w_m = bmsw_pkg::MASK_W'(1);
        end else if (int'(r_mask) > MM) begin
            w_m = bmsw_pkg::MASK_W'(MM);
        end else begin
            w_m = r_mask;
        end
        if (r_fw == '0) begin
            w_w = bmsw_pkg::DIM_W'(1);
        end else if (int'(r_fw) > bmsw_pkg::MAX_WIDTH) begin
            w_w = bmsw_pkg::DIM_W'(bmsw_pkg::MAX_WIDTH);
        end else begin
            w_w = r_fw;
        end
        if (r_fh == '0) begin
            w_h = bmsw_pkg::DIM_W'(1);
        end else if (int'(r_fh) > bmsw_pkg::MAX_HEIGHT) begin
            w_h = bmsw_pkg::DIM_W'(bmsw_pkg::MAX_HEIGHT);
        end else begin
            w_h = r_fh;
        end
        for (int k = 0; k < MM; k++) begin
            w_row_en[k] = (k < int'(w_m));
        end
    end

    assign w_half = w_m >> 1;

    // ---------------- stage 0: accept, count, read line store ----------------
    assign w_inflight = INF_W'(r_s1_v) + INF_W'(r_s2_v) + INF_W'(w_q_count);
    assign o_stall    = (w_inflight >= INF_W'(bmsw_pkg::OUTQ_DEPTH));
    assign w_acc      = i_valid && !o_stall;
    assign w_mark     = (i_pixel == bmsw_pkg::FG_LEVEL);

    assign w_c1       = (bmsw_pkg::DIM_W+1)'(r_col) + 1'b1;
    assign w_r1       = (bmsw_pkg::DIM_W+1)'(r_row) + 1'b1;
    assign w_last_col = (w_c1 == (bmsw_pkg::DIM_W+1)'(w_w));
    assign w_last_row = (w_r1 == (bmsw_pkg::DIM_W+1)'(w_h));
    assign w_has_res  = (w_c1 >= (bmsw_pkg::DIM_W+1)'(w_m)) &&
                        (w_r1 >= (bmsw_pkg::DIM_W+1)'(w_m));
    assign w_pos_c    = w_c1 - (bmsw_pkg::DIM_W+1)'(w_m) + (bmsw_pkg::DIM_W+1)'(w_half);
    assign w_pos_r    = w_r1 - (bmsw_pkg::DIM_W+1)'(w_m) + (bmsw_pkg::DIM_W+1)'(w_half);

    // a write-back to the column being read in the same cycle wins over the RAM
    assign w_hit = r_s1_v && (r_s1_addr == r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_mark <= w_mark;
            r_s1_addr <= r_col;
            r_s1_hit  <= w_hit;
            r_s1_byp  <= w_ls_wr;
            r_s1_res  <= w_has_res;
            r_s1_pc   <= w_pos_c[bmsw_pkg::POS_W-1:0];
            r_s1_pr   <= w_pos_r[bmsw_pkg::POS_W-1:0];
            r_s1_done <= w_last_col && w_last_row;
        end
    end

    bmsw_ram #(
        .WIDTH (bmsw_pkg::LS_W),
        .DEPTH (bmsw_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_addr),
        .i_wdata (w_ls_wr),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_ls_rd)
    );

    // ---------------- stage 1: build column, write back, shift cells ----------------
    // bit k of a column is the mark k rows above the current one
    assign w_prev    = r_s1_hit ? r_s1_byp : w_ls_rd;
    assign w_new_col = {w_prev, r_s1_mark};
    assign w_ls_wr   = w_new_col[bmsw_pkg::LS_W-1:0];

    assign w_chain[0] = w_new_col;

    for (genvar j = 0; j < MM; j++) begin : g_cell
        bmsw_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (r_s1_v),
            .i_col    (w_chain[j]),
            .i_row_en (w_row_en),
            .o_col    (w_chain[j+1]),
            .o_flags  (w_flags[j])
        );
        assign w_all_v[j] = w_flags[j].all_set || !w_row_en[j];
        assign w_any_v[j] = w_flags[j].any_set && w_row_en[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_res  <= r_s1_res;
            r_s2_pc   <= r_s1_pc;
            r_s2_pr   <= r_s1_pr;
            r_s2_done <= r_s1_done;
        end
    end

    // ---------------- stage 2: reduce window, queue result ----------------
    assign w_win_all = &w_all_v;
    assign w_win_any = |w_any_v;

    always_comb begin
        w_res.col  = r_s2_pc;
        w_res.row  = r_s2_pr;
        w_res.done = r_s2_done;
        if (r_mode == bmsw_pkg::MODE_DILATE) begin
            w_res.value = w_win_any ? bmsw_pkg::FG_LEVEL : bmsw_pkg::BG_LEVEL;
        end else begin
            w_res.value = w_win_all ? bmsw_pkg::FG_LEVEL : bmsw_pkg::BG_LEVEL;
        end
    end

    assign w_push = r_s2_v && r_s2_res;

    bmsw_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign o_result_value = w_q_data.value;
    assign o_out_col      = w_q_data.col;
    assign o_out_row      = w_q_data.row;
    assign o_frame_done   = w_q_data.done;

    // ---------------- checks ----------------
    `BMSW_ASSERT_IMPLY(a_queue_room, i_clk, i_rst_n, w_push, w_q_count != bmsw_pkg::OUTQ_CW'(bmsw_pkg::OUTQ_DEPTH))
    `BMSW_ASSERT_NEXT(a_s1_to_s2, i_clk, i_rst_n, r_s1_v, r_s2_v)
    `BMSW_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, i_cfg_we, (r_col == '0) && (r_row == '0))

endmodule
